>>> hdl/tlms_pkg.sv
// tlms_pkg: shared widths, operation codes, status codes and cell control
// struct for the two-list median select block
// no dependencies
package tlms_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

    typedef enum logic [ST_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // per-list control broadcast to every cell of a chain
    typedef struct packed {
        logic load;
        logic pop;
        logic clear;
    } cell_ctl_t;

endpackage

>>> hdl/tlms_ifs.sv
// tlms_req_if / tlms_rsp_if: valid-ready channels for request and result items
// depends on tlms_pkg
interface tlms_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [tlms_pkg::OP_W-1:0]            op;
    logic signed [tlms_pkg::DATA_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface tlms_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tlms_pkg::DATA_W-1:0]   median;
    logic [tlms_pkg::ST_W-1:0]            status;

    modport source (output valid, output median, output status, input ready);
    modport sink   (input valid, input median, input status, output ready);
endinterface

>>> hdl/tlms_cell.sv
// tlms_cell: one storage cell of a list chain; fills when it is the first
// empty cell, takes its upper neighbor's contents on a pop
// depends on tlms_pkg
module tlms_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tlms_pkg::cell_ctl_t                  ctl,
    input  logic signed [tlms_pkg::DATA_W-1:0]   load_value,
    input  logic                                 prev_valid,
    input  logic                                 next_valid,
    input  logic signed [tlms_pkg::DATA_W-1:0]   next_value,
    output logic                                 valid,
    output logic signed [tlms_pkg::DATA_W-1:0]   value
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [tlms_pkg::DATA_W-1:0]  value_reg;
    logic signed [tlms_pkg::DATA_W-1:0]  value_next;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
        else if (ctl.load && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            value_next = load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

>>> hdl/tlms_list.sv
// tlms_list: one list as a row of tlms_cell; the oldest element sits in
// cell 0 and pops shift the row down by one
// depends on tlms_pkg, tlms_cell
module tlms_list #(
    parameter int DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tlms_pkg::cell_ctl_t                  ctl,
    input  logic signed [tlms_pkg::DATA_W-1:0]   load_value,
    output logic                                 head_valid,
    output logic signed [tlms_pkg::DATA_W-1:0]   head_value
);

    logic                                valid_w [DEPTH];
    logic signed [tlms_pkg::DATA_W-1:0]  value_w [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                                prev_valid;
        logic                                next_valid;
        logic signed [tlms_pkg::DATA_W-1:0]  next_value;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_mid
            assign prev_valid = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_valid = 1'b0;
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_valid = valid_w[i+1];
            assign next_value = value_w[i+1];
        end

        tlms_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .load_value (load_value),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .next_value (next_value),
            .valid      (valid_w[i]),
            .value      (value_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_value = value_w[0];

endmodule

>>> hdl/two_list_median_select.sv
// two_list_median_select: lower median of two ascending lists held in two
// cell chains, found by a two-pointer merge walk over the chain heads
// depends on tlms_pkg, tlms_ifs, tlms_list
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | op[1:0], value[31:0] signed
//  rsp     | out | valid / ready | median[31:0] signed, status[1:0]
//
// a load is taken without a walk; a full-list load yields a status item
// a query walks the chain heads for rank+1 pops after acceptance, rank = (n+m-1)/2,
// one chain pop per cycle; an empty-list query answers at once
// req.ready is low during the walk and while an undelivered result waits
// reset empties both lists at once; no clearing pass
module two_list_median_select #(
    parameter int LIST_DEPTH = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    tlms_req_if.sink        req,
    tlms_rsp_if.source      rsp
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                               state_reg, state_next;
    logic [CW-1:0]                        cnt_a_reg, cnt_a_next;
    logic [CW-1:0]                        cnt_b_reg, cnt_b_next;
    logic [CW-1:0]                        remain_reg, remain_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [tlms_pkg::DATA_W-1:0]   median_reg, median_next;
    logic [tlms_pkg::ST_W-1:0]            status_reg, status_next;

    tlms_pkg::cell_ctl_t                  ctl_a, ctl_b;
    logic                                 head_a_valid, head_b_valid;
    logic signed [tlms_pkg::DATA_W-1:0]   head_a, head_b;
    logic                                 slot_free, accept, take_first;
    logic [CW:0]                          sum_m1;

    tlms_list #(.DEPTH(LIST_DEPTH)) u_list_a
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_a),
        .load_value (req.value),
        .head_valid (head_a_valid),
        .head_value (head_a)
    );

    tlms_list #(.DEPTH(LIST_DEPTH)) u_list_b
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_b),
        .load_value (req.value),
        .head_valid (head_b_valid),
        .head_value (head_b)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign sum_m1    = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg} - {{CW{1'b0}}, 1'b1};

    // first list wins ties; an exhausted list never wins
    assign take_first = head_a_valid && (!head_b_valid || (head_a <= head_b));

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        median_next    = median_reg;
        status_next    = status_reg;
        ctl_a          = '0;
        ctl_b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        tlms_pkg::OP_LOAD_FIRST:
                        begin
                            if (cnt_a_reg == CW'(LIST_DEPTH))
                            begin
                                out_valid_next = 1'b1;
                                median_next    = '0;
                                status_next    = tlms_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl_a.load = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                        tlms_pkg::OP_LOAD_SECOND:
                        begin
                            if (cnt_b_reg == CW'(LIST_DEPTH))
                            begin
                                out_valid_next = 1'b1;
                                median_next    = '0;
                                status_next    = tlms_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl_b.load = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                        end
                        tlms_pkg::OP_QUERY:
                        begin
                            if (cnt_a_reg == '0 || cnt_b_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                median_next    = '0;
                                status_next    = tlms_pkg::STATUS_EMPTY;
                                ctl_a.clear    = 1'b1;
                                ctl_b.clear    = 1'b1;
                                cnt_a_next     = '0;
                                cnt_b_next     = '0;
                            end
                            else
                            begin
                                remain_next = sum_m1[CW:1];
                                state_next  = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                ctl_a.pop = take_first;
                ctl_b.pop = !take_first;
                if (remain_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    median_next    = take_first ? head_a : head_b;
                    status_next    = tlms_pkg::STATUS_OK;
                    ctl_a.clear    = 1'b1;
                    ctl_b.clear    = 1'b1;
                    cnt_a_next     = '0;
                    cnt_b_next     = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    remain_next = remain_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            status_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            median_reg    <= median_next;
            status_reg    <= status_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.median = median_reg;
    assign rsp.status = status_reg;

endmodule

>>> tb/two_list_median_select_tb.sv
`timescale 1ns / 1ps
// two_list_median_select_tb: self-checking bench for the two-list median select block
// drives directed and random request items, predicts each result and compares
// depends on tlms_pkg, tlms_ifs and two_list_median_select
module two_list_median_select_tb;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 550;
    localparam int RANDOM_RESULTS = 48;
    localparam int HOLDOFF_AT     = 150;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 16;
    localparam int DIRECTED_ROWS  = 25;

    localparam logic [tlms_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // how a stimulus row is checked
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_TYPED   = 2'd1;
    localparam logic [1:0] ROW_SILENT  = 2'd2;

    localparam logic signed [tlms_pkg::DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic signed [tlms_pkg::DATA_W-1:0] INT_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [tlms_pkg::OP_W-1:0]          op;
        logic signed [tlms_pkg::DATA_W-1:0] value;
        logic [1:0]                         check;
        logic signed [tlms_pkg::DATA_W-1:0] median;
        tlms_pkg::status_t                  status;
    } stim_row_t;

    typedef struct packed {
        logic signed [tlms_pkg::DATA_W-1:0] median;
        tlms_pkg::status_t                  status;
    } median_result_t;

    logic clk;
    logic rst_n;

    tlms_req_if req ();
    tlms_rsp_if rsp ();

    two_list_median_select #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_TYPED,
          32'h0000_0000, tlms_pkg::STATUS_EMPTY},
        '{tlms_pkg::OP_LOAD_FIRST,  INT_MIN,       ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, INT_MAX,       ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'hffff_ffff, ROW_TYPED,
          INT_MIN,       tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, INT_MAX,       ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_TYPED,
          32'h0000_0000, tlms_pkg::STATUS_EMPTY},
        '{tlms_pkg::OP_LOAD_FIRST,  32'hffff_ffff, ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_TYPED,
          32'h0000_0000, tlms_pkg::STATUS_EMPTY},
        '{OP_UNUSED,                32'h1234_5678, ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'h0000_0005, ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, 32'h0000_0005, ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{OP_UNUSED,                32'ha5a5_a5a5, ROW_SILENT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_TYPED,
          32'h0000_0005, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'h0000_0001, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'h0000_0003, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'h0000_0009, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, 32'h0000_0002, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, 32'h0000_0004, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, 32'h0000_0006, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'h0000_0064, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_FIRST,  32'hffff_ffce, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, 32'h0000_0007, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_LOAD_SECOND, INT_MIN,       ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK},
        '{tlms_pkg::OP_QUERY,       32'h0000_0000, ROW_PREDICT,
          32'h0000_0000, tlms_pkg::STATUS_OK}
    };

    stim_row_t      stim_q [$];
    median_result_t pending_results [$];

    // predicted contents of both lists
    logic signed [tlms_pkg::DATA_W-1:0] first_store [LIST_DEPTH];
    logic signed [tlms_pkg::DATA_W-1:0] second_store [LIST_DEPTH];
    int first_cnt;
    int second_cnt;

    int fail_count;
    int rand_items;
    int rand_results;

    int stim_idx;
    int burst_left;
    int gap_left;
    logic signed [tlms_pkg::DATA_W-1:0] pred_median;
    tlms_pkg::status_t                  pred_status;
    bit                                 pred_has;
    median_result_t                     model_result;
    median_result_t                     want;

    int holdoff_left;
    bit holdoff_done;
    int stall_mode;
    int mode_left;
    int rx_cycle;

    function automatic bit predict_median(
        input  logic [tlms_pkg::OP_W-1:0]          op,
        input  logic signed [tlms_pkg::DATA_W-1:0] value,
        output logic signed [tlms_pkg::DATA_W-1:0] median,
        output tlms_pkg::status_t                  status);
        bit produces;
        bit take_first;
        int rank;
        int i;
        int j;
        int k;
        produces = 1'b0;
        median   = '0;
        status   = tlms_pkg::STATUS_OK;
        if (op == tlms_pkg::OP_LOAD_FIRST)
        begin
            if (first_cnt >= LIST_DEPTH)
            begin
                status   = tlms_pkg::STATUS_FULL;
                produces = 1'b1;
            end
            else
            begin
                first_store[first_cnt] = value;
                first_cnt = first_cnt + 1;
            end
        end
        else if (op == tlms_pkg::OP_LOAD_SECOND)
        begin
            if (second_cnt >= LIST_DEPTH)
            begin
                status   = tlms_pkg::STATUS_FULL;
                produces = 1'b1;
            end
            else
            begin
                second_store[second_cnt] = value;
                second_cnt = second_cnt + 1;
            end
        end
        else if (op == tlms_pkg::OP_QUERY)
        begin
            produces = 1'b1;
            if (first_cnt == 0 || second_cnt == 0)
                status = tlms_pkg::STATUS_EMPTY;
            else
            begin
                rank = (first_cnt + second_cnt - 1) / 2;
                i = 0;
                j = 0;
                for (k = 0; k <= rank; k++)
                begin
                    // smaller head wins, first list on ties
                    if (i >= first_cnt)
                        take_first = 1'b0;
                    else if (j >= second_cnt)
                        take_first = 1'b1;
                    else
                        take_first = (first_store[i] <= second_store[j]);
                    if (take_first)
                    begin
                        median = first_store[i];
                        i = i + 1;
                    end
                    else
                    begin
                        median = second_store[j];
                        j = j + 1;
                    end
                end
            end
            first_cnt  = 0;
            second_cnt = 0;
        end
        return produces;
    endfunction

    task automatic add_item(input logic [tlms_pkg::OP_W-1:0] op,
                            input logic signed [tlms_pkg::DATA_W-1:0] value);
        stim_row_t row;
        row.op     = op;
        row.value  = value;
        row.check  = ROW_PREDICT;
        row.median = '0;
        row.status = tlms_pkg::STATUS_OK;
        stim_q.push_back(row);
        if (op != OP_UNUSED)
            rand_items = rand_items + 1;
        if (op == tlms_pkg::OP_QUERY)
            rand_results = rand_results + 1;
    endtask

    function automatic longint start_value();
        case ($urandom_range(0, 3))
            0:       return longint'(INT_MIN);
            1:       return longint'($signed($urandom));
            2:       return longint'($urandom_range(0, 200)) - 100;
            default: return longint'(INT_MAX) - longint'($urandom_range(0, 2000));
        endcase
    endfunction

    // loads n items into the first list and m into the second, interleaved at random
    task automatic add_list_pair(input int n, input int m, input bit sorted);
        longint cur [2];
        int left [2];
        int step_max;
        int sel;
        logic signed [tlms_pkg::DATA_W-1:0] val;
        left[0] = n;
        left[1] = m;
        cur[0]  = start_value();
        cur[1]  = ($urandom_range(0, 1) == 0) ? cur[0] : start_value();
        case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 4;
            2:       step_max = 5000;
            default: step_max = 1 << 24;
        endcase
        while (left[0] + left[1] > 0)
        begin
            if (left[0] == 0)
                sel = 1;
            else if (left[1] == 0)
                sel = 0;
            else
                sel = $urandom_range(0, 1);
            if (sorted)
            begin
                cur[sel] = cur[sel] + longint'($urandom_range(0, step_max));
                if (cur[sel] > longint'(INT_MAX))
                    cur[sel] = longint'(INT_MAX);
                val = cur[sel][tlms_pkg::DATA_W-1:0];
            end
            else
                val = $urandom;
            add_item((sel == 0) ? tlms_pkg::OP_LOAD_FIRST : tlms_pkg::OP_LOAD_SECOND, val);
            left[sel] = left[sel] - 1;
        end
        if (n > LIST_DEPTH)
            rand_results = rand_results + n - LIST_DEPTH;
    endtask

    function automatic int list_size();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(9, LIST_DEPTH);
        return $urandom_range(1, 8);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // request driver; expectations are worked out as each item is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                pred_has = predict_median(stim_q[stim_idx].op, stim_q[stim_idx].value,
                                          pred_median, pred_status);
                if (stim_q[stim_idx].check == ROW_TYPED)
                begin
                    model_result.median = stim_q[stim_idx].median;
                    model_result.status = stim_q[stim_idx].status;
                    pending_results.push_back(model_result);
                end
                else if (stim_q[stim_idx].check == ROW_PREDICT && pred_has)
                begin
                    model_result.median = pred_median;
                    model_result.status = pred_status;
                    pending_results.push_back(model_result);
                end
                stim_idx = stim_idx + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    req.valid <= 1'b0;
                end
                else if (stim_idx < stim_q.size())
                begin
                    req.valid <= 1'b1;
                    req.op    <= stim_q[stim_idx].op;
                    req.value <= stim_q[stim_idx].value;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // result receiver: one long hold-off, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle = rx_cycle + 1;
            if (holdoff_left > 0)
            begin
                holdoff_left = holdoff_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (!holdoff_done && stim_idx >= DIRECTED_ROWS + HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                rsp.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(8, 64);
                end
                mode_left = mode_left - 1;
                case (stall_mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp.ready <= rx_cycle[2];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual median %0d status %0d",
                         $time, rsp.median, rsp.status);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.median !== want.median)
                begin
                    $display("%0t: median mismatch, expected %0d actual %0d",
                             $time, want.median, rsp.median);
                    fail_count = fail_count + 1;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial
    begin
        int kind;
        bit first_seq;
        int depth;
        logic [31:0] rnd;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.op     = tlms_pkg::OP_LOAD_FIRST;
        req.value  = '0;
        rsp.ready  = 1'b0;
        fail_count = 0;
        first_cnt  = 0;
        second_cnt = 0;
        stim_idx   = 0;
        burst_left = 0;
        gap_left   = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        stall_mode   = 0;
        mode_left    = 0;
        rx_cycle     = 0;
        rand_items   = 0;
        rand_results = 0;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            stim_q.push_back(directed_rows[r]);

        // random part: mostly well-formed load runs closed by a query
        first_seq = 1'b1;
        while (rand_items < RANDOM_ITEMS || rand_results < RANDOM_RESULTS)
        begin
            kind = first_seq ? 14 : $urandom_range(0, 19);
            first_seq = 1'b0;
            if (kind <= 12)
            begin
                add_list_pair(list_size(), list_size(), 1'b1);
                if ($urandom_range(0, 9) == 0)
                    add_item(OP_UNUSED, $urandom);
                add_item(tlms_pkg::OP_QUERY, $urandom);
            end
            else if (kind == 13)
            begin
                add_list_pair(list_size(), list_size(), 1'b0);
                add_item(tlms_pkg::OP_QUERY, $urandom);
            end
            else if (kind == 14)
            begin
                // overrun one list past its depth
                depth = LIST_DEPTH + $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 0)
                    add_list_pair(depth, $urandom_range(0, 3), 1'b1);
                else
                    add_list_pair($urandom_range(0, 3), depth, 1'b1);
                add_item(tlms_pkg::OP_QUERY, $urandom);
            end
            else if (kind <= 16)
            begin
                depth = $urandom_range(0, 5);
                if ($urandom_range(0, 1) == 0)
                    add_list_pair(depth, 0, 1'b1);
                else
                    add_list_pair(0, depth, 1'b1);
                add_item(tlms_pkg::OP_QUERY, $urandom);
                if ($urandom_range(0, 3) == 0)
                    add_item(tlms_pkg::OP_QUERY, $urandom);
            end
            else
            begin
                repeat ($urandom_range(3, 8))
                begin
                    rnd = $urandom_range(0, 3);
                    add_item(rnd[tlms_pkg::OP_W-1:0], $urandom);
                end
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_idx < stim_q.size() || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hdl/tlms_pkg.sv
hdl/tlms_ifs.sv
hdl/tlms_cell.sv
hdl/tlms_list.sv
hdl/two_list_median_select.sv
tb/two_list_median_select_tb.sv
